// ----- src/pdlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlc_pkg
// Shared types and codes of the passcode door lock controller.
// ----------------------------------------------------------------------------
package pdlc_pkg;

  typedef logic [2:0] tx_code_t;
  typedef logic [1:0] motor_t;

  localparam tx_code_t TX_NONE          = 3'd0;
  localparam tx_code_t TX_READY_RECEIVE = 3'd1;
  localparam tx_code_t TX_READY_SEND    = 3'd2;
  localparam tx_code_t TX_MATCH         = 3'd3;
  localparam tx_code_t TX_MISMATCH      = 3'd4;
  localparam tx_code_t TX_UNLOCKING     = 3'd5;
  localparam tx_code_t TX_WRONG         = 3'd6;
  localparam tx_code_t TX_CHANGE        = 3'd7;

  localparam motor_t MOT_STOP = 2'd0;
  localparam motor_t MOT_FWD  = 2'd1;
  localparam motor_t MOT_REV  = 2'd2;

  localparam logic [7:0] OPT_OPEN = 8'h2B;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t REG_READY_SEND     = 3'd0;
  localparam cfg_index_t REG_READY_RECEIVE  = 3'd1;
  localparam cfg_index_t REG_CHANGE_OPTION  = 3'd2;
  localparam cfg_index_t REG_UNLOCK_SECONDS = 3'd3;
  localparam cfg_index_t REG_STANDBY_SECS   = 3'd4;
  localparam cfg_index_t REG_ALARM_SECONDS  = 3'd5;
  localparam cfg_index_t REG_ALLOWED_WRONG  = 3'd6;

  typedef struct packed {
    tx_code_t tx_code;
    motor_t   motor;
    logic     buzzer;
    logic     busy_res;
    logic     last;
  } res_word_t;

endpackage

// ----- src/pdlc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlc_req_if / pdlc_res_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pdlc_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface pdlc_res_if;
  import pdlc_pkg::*;
  logic     valid;
  logic     ready;
  tx_code_t tx_code;
  motor_t   motor;
  logic     buzzer;
  logic     busy_res;
  logic     last;

  modport source (output valid, output tx_code, output motor, output buzzer,
                  output busy_res, output last, input ready);
  modport sink   (input valid, input tx_code, input motor, input buzzer,
                  input busy_res, input last, output ready);
endinterface

// ----- src/passcode_door_lock_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// passcode_door_lock_controller_core
// Passcode setup, code check, door motor and alarm sequencing.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while at most two words are queued; a word
//   that ends a setup comparison yields two result words, drained one per cycle
//   while res.ready is high, from a 4-entry queue in the order they were pushed.
// Code digits live in one 2*CODE_LENGTH entry synchronous RAM (two banks),
//   read ahead of use from the address of the next digit position.
// Reset (sync, active high): setup phase, counters cleared, queue empty;
//   the code RAM is not cleared.
module passcode_door_lock_controller_core #(
  parameter int CODE_LENGTH = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  pdlc_pkg::cfg_index_t  cfg_index,
  input  logic [7:0]            cfg_data,
  pdlc_req_if.sink              req,
  pdlc_res_if.source            res
);
  import pdlc_pkg::*;

  localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int DW = $clog2(CODE_LENGTH + 1);
  localparam int AW = $clog2(2 * CODE_LENGTH);
  localparam int DEPTH = 2 * CODE_LENGTH;

  typedef enum logic [3:0] {
    PH_SWAIT1 = 4'd0,
    PH_SENT1  = 4'd1,
    PH_SWAIT2 = 4'd2,
    PH_SENT2  = 4'd3,
    PH_MWAIT  = 4'd4,
    PH_MENT   = 4'd5,
    PH_MOPT   = 4'd6,
    PH_FWD    = 4'd7,
    PH_HOLD   = 4'd8,
    PH_REV    = 4'd9,
    PH_ALARM  = 4'd10
  } phase_t;

  // configuration
  logic [7:0] ready_send_code, ready_receive_code, change_option_code;
  logic [7:0] unlock_seconds, standby_seconds, alarm_seconds;
  logic [3:0] allowed_wrong;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_send_code    <= 8'd16;
      ready_receive_code <= 8'd32;
      change_option_code <= 8'd45;
      unlock_seconds     <= 8'd15;
      standby_seconds    <= 8'd3;
      alarm_seconds      <= 8'd60;
      allowed_wrong      <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_READY_SEND:     ready_send_code    <= cfg_data;
        REG_READY_RECEIVE:  ready_receive_code <= cfg_data;
        REG_CHANGE_OPTION:  change_option_code <= cfg_data;
        REG_UNLOCK_SECONDS: unlock_seconds     <= cfg_data;
        REG_STANDBY_SECS:   standby_seconds    <= cfg_data;
        REG_ALARM_SECONDS:  alarm_seconds      <= cfg_data;
        REG_ALLOWED_WRONG:  allowed_wrong      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // control state
  phase_t        phase, phase_next;
  logic [DW-1:0] digit_index, digit_index_next;
  logic          match_so_far, match_so_far_next;
  logic [7:0]    tick_count, tick_count_next;
  logic [3:0]    wrong_count, wrong_count_next;
  motor_t        motor_drive, motor_drive_next;
  logic          alarm_on, alarm_on_next;
  logic          saved_bank, saved_bank_next;  // bank holding the stored code

  // code RAM
  logic [7:0]    mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    digit;

  // result queue
  res_word_t     queue [4];
  logic [1:0]    wptr, rptr;
  logic [2:0]    count;
  logic          push1, push2, pop;
  res_word_t     word0, word1;

  logic          in_fire;
  logic [IW-1:0] idx, idx_next_clamped;
  logic [DW-1:0] idx_inc;
  logic          m;
  logic [7:0]    tc, period;
  logic [3:0]    wc;
  tx_code_t      tx, tx2;

  assign req.ready = (count <= 3'd2);
  assign in_fire   = req.valid && req.ready;
  assign pop       = res.valid && res.ready;

  assign idx     = (digit_index >= DW'(CODE_LENGTH)) ? IW'(CODE_LENGTH - 1)
                                                    : digit_index[IW-1:0];
  assign idx_inc = DW'(idx) + DW'(1);
  assign digit   = fwd_hit ? fwd_data : mem_rdata;

  always_comb begin
    phase_next        = phase;
    digit_index_next  = digit_index;
    match_so_far_next = match_so_far;
    tick_count_next   = tick_count;
    wrong_count_next  = wrong_count;
    motor_drive_next  = motor_drive;
    alarm_on_next     = alarm_on;
    saved_bank_next   = saved_bank;
    mem_we            = 1'b0;
    mem_waddr         = AW'(idx);
    mem_wdata         = req.rx_byte;
    tx                = TX_NONE;
    tx2               = TX_NONE;
    push1             = 1'b0;
    push2             = 1'b0;
    m                 = match_so_far;
    tc                = tick_count;
    period            = unlock_seconds;
    wc                = wrong_count + 4'd1;

    if (in_fire) begin
      push1 = 1'b1;
      if (req.mode) begin
        if (phase >= PH_FWD && phase <= PH_ALARM) begin
          if (tick_count != 8'hFF) tc = tick_count + 8'd1;
          if (phase == PH_HOLD)       period = standby_seconds;
          else if (phase == PH_ALARM) period = alarm_seconds;
          tick_count_next = tc;
          if (tc >= period) begin
            tick_count_next = 8'd0;
            unique case (phase)
              PH_FWD: begin
                motor_drive_next = MOT_STOP;
                phase_next       = PH_HOLD;
              end
              PH_HOLD: begin
                motor_drive_next = MOT_REV;
                phase_next       = PH_REV;
              end
              PH_REV: begin
                motor_drive_next = MOT_STOP;
                phase_next       = PH_MWAIT;
              end
              default: begin
                alarm_on_next    = 1'b0;
                wrong_count_next = 4'd0;
                phase_next       = PH_MWAIT;
              end
            endcase
          end
        end
      end else begin
        unique case (phase)
          PH_SWAIT1, PH_SWAIT2: begin
            if (req.rx_byte == ready_send_code) begin
              tx                = TX_READY_RECEIVE;
              digit_index_next  = '0;
              match_so_far_next = 1'b1;
              phase_next        = (phase == PH_SWAIT1) ? PH_SENT1 : PH_SENT2;
            end
          end
          PH_SENT1: begin
            mem_we           = 1'b1;
            mem_waddr        = saved_bank ? AW'(idx) : AW'(idx) + AW'(CODE_LENGTH);
            digit_index_next = idx_inc;
            if (idx_inc >= DW'(CODE_LENGTH)) phase_next = PH_SWAIT2;
          end
          PH_SENT2: begin
            m                 = match_so_far && (digit == req.rx_byte);
            match_so_far_next = m;
            digit_index_next  = idx_inc;
            if (idx_inc >= DW'(CODE_LENGTH)) begin
              push2 = 1'b1;
              tx    = TX_READY_SEND;
              if (m) begin
                saved_bank_next = ~saved_bank;  // entry bank becomes stored code
                phase_next      = PH_MWAIT;
                tx2             = TX_MATCH;
              end else begin
                phase_next = PH_SWAIT1;
                tx2        = TX_MISMATCH;
              end
            end
          end
          PH_MWAIT: begin
            if (req.rx_byte == ready_send_code) begin
              digit_index_next  = '0;
              match_so_far_next = 1'b1;
              phase_next        = PH_MENT;
            end
          end
          PH_MENT: begin
            if (digit != req.rx_byte) match_so_far_next = 1'b0;
            digit_index_next = idx_inc;
            if (idx_inc >= DW'(CODE_LENGTH)) phase_next = PH_MOPT;
          end
          PH_MOPT: begin
            if (req.rx_byte == OPT_OPEN || req.rx_byte == change_option_code) begin
              if (match_so_far) begin
                if (req.rx_byte == OPT_OPEN) begin
                  tx               = TX_UNLOCKING;
                  motor_drive_next = MOT_FWD;
                  tick_count_next  = 8'd0;
                  phase_next       = PH_FWD;
                end else begin
                  tx         = TX_CHANGE;
                  phase_next = PH_SWAIT1;
                end
              end else begin
                tx               = TX_WRONG;
                wrong_count_next = wc;
                if (wc == allowed_wrong) begin
                  alarm_on_next   = 1'b1;
                  tick_count_next = 8'd0;
                  phase_next      = PH_ALARM;
                end else begin
                  phase_next = PH_MWAIT;
                end
              end
            end else begin
              phase_next = PH_MWAIT;
            end
          end
          default: ;  // busy: byte dropped
        endcase
      end
    end
  end

  // prefetch the digit the next word will need
  assign idx_next_clamped = (digit_index_next >= DW'(CODE_LENGTH)) ?
                            IW'(CODE_LENGTH - 1) : digit_index_next[IW-1:0];

  always_comb begin
    if ((phase_next == PH_MENT) == saved_bank_next)
      mem_raddr = AW'(idx_next_clamped) + AW'(CODE_LENGTH);
    else
      mem_raddr = AW'(idx_next_clamped);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
    fwd_hit   <= mem_we && (mem_waddr == mem_raddr);
    fwd_data  <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SWAIT1;
      digit_index  <= '0;
      match_so_far <= 1'b1;
      tick_count   <= 8'd0;
      wrong_count  <= 4'd0;
      motor_drive  <= MOT_STOP;
      alarm_on     <= 1'b0;
      saved_bank   <= 1'b0;
    end else begin
      phase        <= phase_next;
      digit_index  <= digit_index_next;
      match_so_far <= match_so_far_next;
      tick_count   <= tick_count_next;
      wrong_count  <= wrong_count_next;
      motor_drive  <= motor_drive_next;
      alarm_on     <= alarm_on_next;
      saved_bank   <= saved_bank_next;
    end
  end

  // result words carry the state after this input
  always_comb begin
    word0.tx_code  = tx;
    word0.motor    = motor_drive_next;
    word0.buzzer   = alarm_on_next;
    word0.busy_res = (phase_next >= PH_FWD);
    word0.last     = ~push2;
    word1          = word0;
    word1.tx_code  = tx2;
    word1.last     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push1) queue[wptr] <= word0;
    if (push2) queue[wptr + 2'd1] <= word1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      wptr  <= wptr + {1'b0, push1} + {1'b0, push2};
      rptr  <= rptr + {1'b0, pop};
      count <= count + {2'b00, push1} + {2'b00, push2} - {2'b00, pop};
    end
  end

  assign res.valid    = (count != 3'd0);
  assign res.tx_code  = queue[rptr].tx_code;
  assign res.motor    = queue[rptr].motor;
  assign res.buzzer   = queue[rptr].buzzer;
  assign res.busy_res = queue[rptr].busy_res;
  assign res.last     = queue[rptr].last;

endmodule

// ----- bench/tb_passcode_door_lock_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_passcode_door_lock_controller_core
// Drives received bytes and one-second ticks into the lock controller. A
// scoreboard with its own copy of the lock state predicts every result word
// and compares it field by field. The run steps through several register
// settings and applies random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_passcode_door_lock_controller_core;
  import pdlc_pkg::*;

  localparam int CODE_LEN = 5;

  typedef enum logic [3:0] {
    SET_WAIT_A, SET_CODE_A, SET_WAIT_B, SET_CODE_B,
    LOCK_WAIT, LOCK_CODE, LOCK_OPTION,
    DOOR_OPENING, DOOR_OPEN, DOOR_CLOSING, ALARM
  } lock_phase_t;

  typedef logic [CODE_LEN-1:0][7:0] passcode_t;

  class lock_response_tracker;
    logic [7:0]  ready_send, ready_receive, change_opt;
    logic [7:0]  unlock_secs, standby_secs, alarm_secs;
    logic [3:0]  allowed_wrong;
    lock_phase_t ph;
    logic [3:0]  digit;
    passcode_t   first_entry, saved_code;
    logic        match_ok;
    logic [7:0]  tick_cnt;
    logic [3:0]  wrong_cnt;
    motor_t      motor_drv;
    logic        alarm_on;
    res_word_t   pending_words[$];
    int          errors, words_in, words_out, openings, alarms, codes_stored;

    function new();
      ready_send    = 8'd16;
      ready_receive = 8'd32;
      change_opt    = 8'd45;
      unlock_secs   = 8'd15;
      standby_secs  = 8'd3;
      alarm_secs    = 8'd60;
      allowed_wrong = 4'd3;
      ph            = SET_WAIT_A;
      digit         = '0;
      first_entry   = '0;
      saved_code    = '0;
      match_ok      = 1'b1;
      tick_cnt      = '0;
      wrong_cnt     = '0;
      motor_drv     = MOT_STOP;
      alarm_on      = 1'b0;
      errors        = 0;
      words_in      = 0;
      words_out     = 0;
      openings      = 0;
      alarms        = 0;
      codes_stored  = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [7:0] v);
      case (idx)
        REG_READY_SEND:     ready_send    = v;
        REG_READY_RECEIVE:  ready_receive = v;
        REG_CHANGE_OPTION:  change_opt    = v;
        REG_UNLOCK_SECONDS: unlock_secs   = v;
        REG_STANDBY_SECS:   standby_secs  = v;
        REG_ALARM_SECONDS:  alarm_secs    = v;
        REG_ALLOWED_WRONG:  allowed_wrong = v[3:0];
        default: ;
      endcase
    endfunction

    // status fields reflect the state after the word is processed
    function void queue_result(tx_code_t tx, logic fin);
      res_word_t w;
      w.tx_code  = tx;
      w.motor    = motor_drv;
      w.buzzer   = alarm_on;
      w.busy_res = (ph >= DOOR_OPENING);
      w.last     = fin;
      pending_words.push_back(w);
    endfunction

    function tx_code_t count_wrong();
      wrong_cnt = wrong_cnt + 4'd1;
      if (wrong_cnt == allowed_wrong) begin
        alarm_on = 1'b1;
        tick_cnt = '0;
        ph       = ALARM;
        alarms++;
      end else begin
        ph = LOCK_WAIT;
      end
      return TX_WRONG;
    endfunction

    function void note_word(logic mode, logic [7:0] rx);
      tx_code_t   tx;
      logic [7:0] period;
      int         i;
      tx = TX_NONE;
      words_in++;
      if (mode) begin
        if (ph >= DOOR_OPENING) begin
          if (tick_cnt != 8'hFF) tick_cnt++;
          if (ph == DOOR_OPEN) period = standby_secs;
          else if (ph == ALARM) period = alarm_secs;
          else period = unlock_secs;
          if (tick_cnt >= period) begin
            tick_cnt = '0;
            case (ph)
              DOOR_OPENING: begin
                motor_drv = MOT_STOP;
                ph        = DOOR_OPEN;
              end
              DOOR_OPEN: begin
                motor_drv = MOT_REV;
                ph        = DOOR_CLOSING;
              end
              DOOR_CLOSING: begin
                motor_drv = MOT_STOP;
                ph        = LOCK_WAIT;
              end
              default: begin
                alarm_on  = 1'b0;
                wrong_cnt = '0;
                ph        = LOCK_WAIT;
              end
            endcase
          end
        end
        queue_result(TX_NONE, 1'b1);
        return;
      end
      i = (digit >= CODE_LEN) ? CODE_LEN - 1 : int'(digit);
      case (ph)
        SET_WAIT_A, SET_WAIT_B: begin
          if (rx == ready_send) begin
            tx       = TX_READY_RECEIVE;
            digit    = '0;
            match_ok = 1'b1;
            if (ph == SET_WAIT_A) ph = SET_CODE_A;
            else ph = SET_CODE_B;
          end
        end
        SET_CODE_A: begin
          first_entry[i] = rx;
          digit = 4'(i + 1);
          if (digit >= CODE_LEN) ph = SET_WAIT_B;
        end
        SET_CODE_B: begin
          if (first_entry[i] != rx) match_ok = 1'b0;
          digit = 4'(i + 1);
          if (digit >= CODE_LEN) begin
            // comparison done: ready-send word, then the verdict
            if (match_ok) begin
              saved_code = first_entry;
              ph         = LOCK_WAIT;
              tx         = TX_MATCH;
              codes_stored++;
            end else begin
              ph = SET_WAIT_A;
              tx = TX_MISMATCH;
            end
            queue_result(TX_READY_SEND, 1'b0);
            queue_result(tx, 1'b1);
            return;
          end
        end
        LOCK_WAIT: begin
          if (rx == ready_send) begin
            digit    = '0;
            match_ok = 1'b1;
            ph       = LOCK_CODE;
          end
        end
        LOCK_CODE: begin
          first_entry[i] = rx;
          if (saved_code[i] != rx) match_ok = 1'b0;
          digit = 4'(i + 1);
          if (digit >= CODE_LEN) ph = LOCK_OPTION;
        end
        LOCK_OPTION: begin
          // open option wins when it equals the change option
          if (rx == OPT_OPEN) begin
            if (match_ok) begin
              tx        = TX_UNLOCKING;
              motor_drv = MOT_FWD;
              tick_cnt  = '0;
              ph        = DOOR_OPENING;
              openings++;
            end else begin
              tx = count_wrong();
            end
          end else if (rx == change_opt) begin
            if (match_ok) begin
              tx = TX_CHANGE;
              ph = SET_WAIT_A;
            end else begin
              tx = count_wrong();
            end
          end else begin
            ph = LOCK_WAIT;
          end
        end
        default: ;  // busy: byte dropped
      endcase
      queue_result(tx, 1'b1);
    endfunction

    function void check_word(res_word_t got);
      res_word_t want;
      words_out++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending: tx_code %0d motor %0d", got.tx_code,
               got.motor);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.tx_code !== want.tx_code) begin
        $error("tx_code: expected %0d, got %0d", want.tx_code, got.tx_code);
        errors++;
      end
      if (got.motor !== want.motor) begin
        $error("motor: expected %0d, got %0d", want.motor, got.motor);
        errors++;
      end
      if (got.buzzer !== want.buzzer) begin
        $error("buzzer: expected %0b, got %0b", want.buzzer, got.buzzer);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [7:0] cfg_data;
  logic       idling = 1'b0;
  logic       quiet = 1'b0;
  int         stall_left = 0;
  int         settings_run = 0;

  pdlc_req_if req_if ();
  pdlc_res_if res_if ();

  lock_response_tracker tracker;

  passcode_door_lock_controller_core #(
    .CODE_LENGTH(CODE_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_if),
    .res      (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      tracker.check_word({res_if.tx_code, res_if.motor, res_if.buzzer, res_if.busy_res,
                          res_if.last});
  end

  task automatic send_word(input logic m, input logic [7:0] b);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.rx_byte <= b;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    tracker.note_word(m, b);
  endtask

  task automatic send_noise();
    send_word(1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic send_entry(input passcode_t c);
    send_word(1'b0, tracker.ready_send);
    for (int k = 0; k < CODE_LEN; k++) send_word(1'b0, c[k]);
  endtask

  function automatic passcode_t garble(passcode_t c);
    c[$urandom_range(0, CODE_LEN - 1)] ^= 8'($urandom_range(1, 255));
    if ($urandom_range(0, 2) == 0) c[$urandom_range(0, CODE_LEN - 1)] ^= 8'($urandom);
    return c;
  endfunction

  // wait for every pending word, then add an idle margin
  task automatic settle();
    int guard;
    req_if.valid <= 1'b0;
    guard = 0;
    while (tracker.pending_words.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    tracker.write_reg(idx, v);
  endtask

  task automatic load_settings(input logic [7:0] rs, input logic [7:0] rr,
                               input logic [7:0] co, input logic [7:0] us,
                               input logic [7:0] ss, input logic [7:0] as,
                               input logic [3:0] aw);
    settle();
    write_reg(REG_READY_SEND, rs);
    write_reg(REG_READY_RECEIVE, rr);
    write_reg(REG_CHANGE_OPTION, co);
    write_reg(REG_UNLOCK_SECONDS, us);
    write_reg(REG_STANDBY_SECS, ss);
    write_reg(REG_ALARM_SECONDS, as);
    write_reg(REG_ALLOWED_WRONG, {4'd0, aw});
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // mostly well-formed setup and unlock sequences, some noise and bad codes
  task automatic run_traffic(input int budget);
    passcode_t c;
    int        start;
    int        pick;
    start = tracker.words_in;
    while (tracker.words_in - start < budget) begin
      if (!quiet && $urandom_range(0, 19) == 0) idling <= ~idling;
      pick = $urandom_range(0, 99);
      case (tracker.ph)
        SET_WAIT_A: begin
          if (pick < 85) send_entry(passcode_t'({$urandom, 8'($urandom)}));
          else send_noise();
        end
        SET_WAIT_B: begin
          if (pick < 85) begin
            c = tracker.first_entry;
            if ($urandom_range(0, 3) == 0) c = garble(c);
            send_entry(c);
          end else begin
            send_noise();
          end
        end
        LOCK_WAIT: begin
          if (pick < 85) begin
            c = tracker.saved_code;
            if ($urandom_range(0, 99) < 35) c = garble(c);
            send_entry(c);
            pick = $urandom_range(0, 99);
            if (pick < 50) send_word(1'b0, OPT_OPEN);
            else if (pick < 75) send_word(1'b0, tracker.change_opt);
            else if (pick < 90) send_word(1'b0, 8'($urandom));
          end else begin
            send_noise();
          end
        end
        SET_CODE_A, SET_CODE_B, LOCK_CODE, LOCK_OPTION: begin
          if (pick < 85) send_word(1'b0, 8'($urandom));
          else send_noise();
        end
        default: begin
          if (pick < 90) send_word(1'b1, 8'($urandom));
          else send_word(1'b0, 8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    passcode_t first;
    tracker        = new();
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_READY_SEND;
    cfg_data       <= 8'd0;
    req_if.valid   <= 1'b0;
    req_if.mode    <= 1'b0;
    req_if.rx_byte <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray words before setup, then a mismatching and a matching setup
    first = {8'hFF, 8'h00, 8'h10, 8'h2B, 8'h80};
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'hFF);
    send_entry(first);
    send_entry(first ^ 40'h01);
    send_entry(first);
    send_entry(first);

    idling = 1'b1;
    load_settings(8'h00, 8'h00, 8'h00, 8'd1, 8'd1, 8'd1, 4'd1);
    run_traffic(100);
    load_settings(8'hFF, 8'hFF, OPT_OPEN, 8'd3, 8'd2, 8'd4, 4'd15);
    run_traffic(120);
    repeat (3) begin
      load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                    4'($urandom_range(1, 4)));
      run_traffic(90);
    end
    load_settings(8'd16, 8'd32, 8'd45, 8'd255, 8'd255, 8'd255, 4'd2);
    run_traffic(170);

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    idling <= 1'b0;
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)),
                  8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                  4'($urandom_range(1, 3)));
    run_traffic(120);

    settle();
    if (tracker.pending_words.size() != 0) begin
      $error("%0d expected result words never arrived", tracker.pending_words.size());
      tracker.errors++;
    end
    $display("Drove %0d words, checked %0d result words over %0d register settings;",
             tracker.words_in, tracker.words_out, settings_run);
    $display("%0d codes stored, %0d door openings, %0d alarms.", tracker.codes_stored,
             tracker.openings, tracker.alarms);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
